[src/rasr_pkg.sv]
package rasr_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_GCD,
      ST_DIVN,
      ST_DIVD
   } state_type;

   typedef enum logic [1:0] {
      PH_CROSS1,
      PH_CROSS2,
      PH_DEN
   } phase_type;

endpackage

[src/rational_add_subtract_reduce.sv]
// zero offset numerator gives its result in the cycle after the transfer; otherwise the item
// runs shift-add multiply steps (general case only, ends early when the multiplier runs out
// of ones), a prep step, binary gcd steps and then the numerator and denominator divides
// a new item is taken only while idle; busy stays high while an item is in work
// arithmetic runs as shift-add multiply, binary gcd and restoring divide steps under a small sequencer
// reset (synchronous) returns to idle and clears the strobe; the receiver cannot stall
module rational_add_subtract_reduce #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic signed [VALUE_WIDTH-1:0] req_base_num,
   input  logic signed [VALUE_WIDTH-1:0] req_base_den,
   input  logic signed [VALUE_WIDTH-1:0] req_offset_num,
   input  logic signed [VALUE_WIDTH-1:0] req_offset_den,
   output logic                          rsp_valid,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_num,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_den
);

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(VALUE_WIDTH);
   localparam logic [W-1:0] ONE  = W'(1);
   localparam logic [W-1:0] ZERO = '0;
   localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);

   function automatic logic [W-1:0] neg(input logic [W-1:0] x);
      return ~x + ONE;
   endfunction

   function automatic logic [W-1:0] mag(input logic [W-1:0] x);
      return x[W-1] ? (~x + ONE) : x;
   endfunction

   rasr_pkg::state_type state_ff, state_in;
   rasr_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  op_a_ff, op_a_in;
   logic [W-1:0]  op_b_ff, op_b_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W-1:0]  d1_ff, d1_in;
   logic [W-1:0]  d2_ff, d2_in;
   logic [W-1:0]  sn2_ff, sn2_in;
   logic [W-1:0]  g_ff, g_in;
   logic          neg_ff, neg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_num_ff, rsp_num_in;
   logic [W-1:0]  rsp_den_ff, rsp_den_in;

   logic [W-1:0]  n1, d1, n2, d2, sn2_req, t_opp;
   logic          gcd_end;
   logic [W-1:0]  gcd_g;
   logic [W:0]    gcd_diff;
   logic [W-1:0]  rem_sh;
   logic [W:0]    trial;
   logic          qbit;
   logic [W-1:0]  quot;
   logic          div_last;

   assign n1 = req_base_num;
   assign d1 = req_base_den;
   assign n2 = req_offset_num;
   assign d2 = req_offset_den;
   assign sn2_req = req_operation ? neg(n2) : n2;
   assign t_opp = n1 - sn2_req;

   // binary gcd: common power of two is counted in cnt_ff
   assign gcd_end  = (op_a_ff == ZERO) || (op_b_ff == ZERO);
   assign gcd_g    = ((op_a_ff == ZERO) ? op_b_ff : op_a_ff) << cnt_ff;
   assign gcd_diff = {1'b0, op_a_ff} - {1'b0, op_b_ff};

   // restoring division, dividend shifts out of op_a while quotient shifts in
   assign rem_sh   = {acc_ff[W-2:0], op_a_ff[W-1]};
   assign trial    = {1'b0, rem_sh} - {1'b0, g_ff};
   assign qbit     = ~trial[W];
   assign quot     = {op_a_ff[W-2:0], qbit};
   assign div_last = (cnt_ff == LAST_BIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rasr_pkg::ST_IDLE: begin
            if (start) begin
               if (n2 == ZERO) begin
                  state_in = rasr_pkg::ST_IDLE;
               end else if ((d2 == d1) || (d2 == neg(d1))) begin
                  state_in = rasr_pkg::ST_PREP;
               end else begin
                  state_in = rasr_pkg::ST_MUL;
               end
            end
         end
         rasr_pkg::ST_MUL: begin
            if ((op_b_ff == ZERO) && (phase_ff == rasr_pkg::PH_DEN)) begin
               state_in = rasr_pkg::ST_PREP;
            end
         end
         rasr_pkg::ST_PREP: begin
            state_in = rasr_pkg::ST_GCD;
         end
         rasr_pkg::ST_GCD: begin
            if (gcd_end) begin
               state_in = (gcd_g == ZERO) ? rasr_pkg::ST_IDLE : rasr_pkg::ST_DIVN;
            end
         end
         rasr_pkg::ST_DIVN: begin
            if (div_last) begin
               state_in = rasr_pkg::ST_DIVD;
            end
         end
         rasr_pkg::ST_DIVD: begin
            if (div_last) begin
               state_in = rasr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rasr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      sn2_in       = sn2_ff;
      g_in         = g_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      case (state_ff)
         rasr_pkg::ST_IDLE: begin
            if (start) begin
               d1_in  = d1;
               d2_in  = d2;
               sn2_in = sn2_req;
               neg_in = 1'b0;
               if (n2 == ZERO) begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = n1;
                  rsp_den_in   = d1;
               end else if (d2 == d1) begin
                  num_in = n1 + sn2_req;
                  den_in = d1;
               end else if (d2 == neg(d1)) begin
                  num_in = d1[W-1] ? t_opp : neg(t_opp);
                  den_in = d1[W-1] ? d1 : neg(d1);
               end else begin
                  op_a_in  = n1;
                  op_b_in  = d2;
                  acc_in   = ZERO;
                  phase_in = rasr_pkg::PH_CROSS1;
                  neg_in   = d1[W-1];
               end
            end
         end
         rasr_pkg::ST_MUL: begin
            if (op_b_ff != ZERO) begin
               acc_in  = acc_ff + (op_b_ff[0] ? op_a_ff : ZERO);
               op_a_in = {op_a_ff[W-2:0], 1'b0};
               op_b_in = {1'b0, op_b_ff[W-1:1]};
            end else begin
               case (phase_ff)
                  rasr_pkg::PH_CROSS1: begin
                     op_a_in  = sn2_ff;
                     op_b_in  = d1_ff;
                     phase_in = rasr_pkg::PH_CROSS2;
                  end
                  rasr_pkg::PH_CROSS2: begin
                     num_in   = acc_ff;
                     acc_in   = ZERO;
                     op_a_in  = d1_ff;
                     op_b_in  = d2_ff;
                     phase_in = rasr_pkg::PH_DEN;
                  end
                  default: begin
                     den_in = acc_ff;
                  end
               endcase
            end
         end
         rasr_pkg::ST_PREP: begin
            // magnitudes do not change under the sign flip, so they come straight off
            num_in  = neg_ff ? neg(num_ff) : num_ff;
            den_in  = neg_ff ? neg(den_ff) : den_ff;
            op_a_in = mag(num_ff);
            op_b_in = mag(den_ff);
            cnt_in  = '0;
         end
         rasr_pkg::ST_GCD: begin
            if (gcd_end) begin
               g_in    = gcd_g;
               op_a_in = mag(num_ff);
               acc_in  = ZERO;
               cnt_in  = '0;
               if (gcd_g == ZERO) begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = num_ff;
                  rsp_den_in   = den_ff;
               end
            end else if (!op_a_ff[0] && !op_b_ff[0]) begin
               op_a_in = {1'b0, op_a_ff[W-1:1]};
               op_b_in = {1'b0, op_b_ff[W-1:1]};
               cnt_in  = cnt_ff + 1'b1;
            end else if (!op_a_ff[0]) begin
               op_a_in = {1'b0, op_a_ff[W-1:1]};
            end else if (!op_b_ff[0]) begin
               op_b_in = {1'b0, op_b_ff[W-1:1]};
            end else if (!gcd_diff[W]) begin
               op_a_in = gcd_diff[W-1:0];
            end else begin
               op_b_in = neg(gcd_diff[W-1:0]);
            end
         end
         rasr_pkg::ST_DIVN, rasr_pkg::ST_DIVD: begin
            acc_in  = qbit ? trial[W-1:0] : rem_sh;
            op_a_in = quot;
            cnt_in  = cnt_ff + 1'b1;
            if (div_last) begin
               if (state_ff == rasr_pkg::ST_DIVN) begin
                  num_in  = num_ff[W-1] ? neg(quot) : quot;
                  op_a_in = mag(den_ff);
                  acc_in  = ZERO;
                  cnt_in  = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = num_ff;
                  rsp_den_in   = den_ff[W-1] ? neg(quot) : quot;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rasr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      cnt_ff     <= cnt_in;
      op_a_ff    <= op_a_in;
      op_b_ff    <= op_b_in;
      acc_ff     <= acc_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      sn2_ff     <= sn2_in;
      g_ff       <= g_in;
      neg_ff     <= neg_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign busy           = (state_ff != rasr_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_num = rsp_num_ff;
   assign rsp_result_den = rsp_den_ff;

endmodule

[tb/sv/rational_add_subtract_reduce_tb.sv]
module rational_add_subtract_reduce_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = 32;
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;
   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 3 * (W + 1) + 1 + (4 * W + 1) + 2 * W + 20;

   typedef logic [W-1:0] word_type;

   localparam word_type MOST_NEG  = {1'b1, {(W-1){1'b0}}};
   localparam word_type MOST_POS  = {1'b0, {(W-1){1'b1}}};
   localparam word_type MINUS_ONE = {W{1'b1}};

   typedef struct packed {
      word_type num;
      word_type den;
   } fraction_type;

   typedef struct packed {
      logic     op;
      word_type n1;
      word_type d1;
      word_type n2;
      word_type d2;
      logic     known;
      word_type want_num;
      word_type want_den;
   } directed_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     operation = 1'b0;
   word_type base_num = '0;
   word_type base_den = '0;
   word_type offset_num = '0;
   word_type offset_den = '0;
   logic     busy;
   logic     rsp_valid;
   logic signed [W-1:0] rsp_result_num;
   logic signed [W-1:0] rsp_result_den;

   fraction_type pending_sums[$];
   int           mismatch_count = 0;
   bit           idle_on = 1'b1;

   rational_add_subtract_reduce #(
      .VALUE_WIDTH(W)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (operation),
      .req_base_num  (base_num),
      .req_base_den  (base_den),
      .req_offset_num(offset_num),
      .req_offset_den(offset_den),
      .rsp_valid     (rsp_valid),
      .rsp_result_num(rsp_result_num),
      .rsp_result_den(rsp_result_den)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic word_type magnitude(word_type x);
      word_type m;
      m = x[W-1] ? -x : x;
      return m;
   endfunction

   function automatic word_type gcd_of(word_type a, word_type b);
      word_type x;
      word_type y;
      word_type t;
      x = a;
      y = b;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // divide the magnitude, then put the sign back
   function automatic word_type divide_out(word_type x, word_type g);
      word_type q;
      q = magnitude(x) / g;
      return x[W-1] ? -q : q;
   endfunction

   function automatic fraction_type sum_fraction(logic op, word_type n1, word_type d1,
                                                 word_type n2, word_type d2);
      word_type     signed_n2;
      word_type     t;
      word_type     g;
      fraction_type r;
      signed_n2 = (op == OP_SUB) ? -n2 : n2;
      if (n2 == 0) begin
         r.num = n1;
         r.den = d1;
         return r;
      end
      if (d2 == d1) begin
         r.num = n1 + signed_n2;
         r.den = d1;
      end else if (d2 == word_type'(-d1)) begin
         t = n1 - signed_n2;
         if (d1[W-1]) begin
            r.num = t;
            r.den = d1;
         end else begin
            r.num = -t;
            r.den = -d1;
         end
      end else begin
         r.num = n1 * d2 + signed_n2 * d1;
         r.den = d1 * d2;
         if (d1[W-1]) begin
            r.num = -r.num;
            r.den = -r.den;
         end
      end
      g = gcd_of(magnitude(r.num), magnitude(r.den));
      if (g != 0) begin
         r.num = divide_out(r.num, g);
         r.den = divide_out(r.den, g);
      end
      return r;
   endfunction

   function automatic word_type pick_word(int span);
      int       v;
      word_type w;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: w = '0;
               1: w = 1;
               2: w = MINUS_ONE;
               3: w = MOST_POS;
               default: w = MOST_NEG;
            endcase
         end
         1, 2: w = $urandom;
         default: begin
            v = $urandom_range(0, 2 * span);
            w = v - span;
         end
      endcase
      return w;
   endfunction

   // start stays high across back-to-back items, so it is only lowered when a gap is drawn
   task automatic transfer_item(input logic op, input word_type n1, input word_type d1,
                                input word_type n2, input word_type d2,
                                input logic known, input fraction_type want);
      int           gap;
      fraction_type target;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      <= 1'b1;
      operation  <= op;
      base_num   <= n1;
      base_den   <= d1;
      offset_num <= n2;
      offset_den <= d2;
      target = known ? want : sum_fraction(op, n1, d1, n2, d2);
      do @(posedge clock); while (busy);
      pending_sums.push_back(target);
   endtask

   always @(posedge clock) begin
      fraction_type want;
      if (!reset && rsp_valid) begin
         if (pending_sums.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result %0d/%0d", rsp_result_num, rsp_result_den);
            mismatch_count++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_result_num !== want.num || rsp_result_den !== want.den) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected %0d/%0d, got %0d/%0d",
                           $signed(want.num), $signed(want.den),
                           rsp_result_num, rsp_result_den);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      int               span;
      int               kind;
      word_type         n1;
      word_type         d1;
      word_type         n2;
      word_type         d2;

      // zero offset numerator passes the base through untouched
      rows.push_back(directed_row_type'{OP_ADD, 32'd5, 32'd7, 32'd0, 32'd3, 1'b1, 32'd5, 32'd7});
      rows.push_back(directed_row_type'{OP_SUB, MOST_NEG, 32'd0, 32'd0, MINUS_ONE,
                                        1'b1, MOST_NEG, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, MOST_POS, MINUS_ONE, 32'd0, 32'd0,
                                        1'b1, MOST_POS, MINUS_ONE});
      // both zero after the sum, so no reduction
      rows.push_back(directed_row_type'{OP_ADD, 32'd3, 32'd0, -32'sd3, 32'd0,
                                        1'b1, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, 32'd1, 32'd2, 32'd1, 32'd2,
                                        1'b1, 32'd1, 32'd1});
      rows.push_back(directed_row_type'{OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2,
                                        1'b1, 32'd0, 32'd1});
      // opposite denominators, base denominator negative and positive
      rows.push_back(directed_row_type'{OP_ADD, 32'd1, -32'sd2, 32'd1, 32'd2,
                                        1'b1, 32'd0, MINUS_ONE});
      rows.push_back(directed_row_type'{OP_ADD, 32'd1, 32'd2, 32'd3, -32'sd2,
                                        1'b1, 32'd1, MINUS_ONE});
      rows.push_back(directed_row_type'{OP_SUB, 32'd1, 32'd2, 32'd3, -32'sd2,
                                        1'b1, -32'sd2, MINUS_ONE});
      // wrap at the extremes
      rows.push_back(directed_row_type'{OP_ADD, MOST_POS, 32'd1, MOST_POS, 32'd1,
                                        1'b1, -32'sd2, 32'd1});
      rows.push_back(directed_row_type'{OP_SUB, MOST_NEG, 32'd1, 32'd1, 32'd1,
                                        1'b1, MOST_POS, 32'd1});
      rows.push_back(directed_row_type'{OP_ADD, 32'd1, 32'd3, 32'd1, 32'd6,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_SUB, 32'd1, -32'sd3, 32'd1, 32'd4,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_SUB, MOST_NEG, MOST_NEG, 32'd1, 32'd1,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, 32'd1, MOST_NEG, 32'd1, MOST_NEG,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, MOST_POS, MOST_POS, MOST_POS, MOST_NEG,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, 32'd1, 32'd0, 32'd1, 32'd5,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_SUB, MINUS_ONE, MINUS_ONE, MINUS_ONE, MINUS_ONE,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, MOST_NEG, 32'd1, MOST_NEG, MINUS_ONE,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_SUB, 32'd6, 32'd4, 32'd9, -32'sd6,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, 32'd12, 32'd0, 32'd5, 32'd0,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_ADD, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS,
                                        1'b0, 32'd0, 32'd0});
      rows.push_back(directed_row_type'{OP_SUB, 32'd0, 32'd5, MOST_NEG, 32'd3,
                                        1'b0, 32'd0, 32'd0});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         transfer_item(rows[i].op, rows[i].n1, rows[i].d1, rows[i].n2, rows[i].d2,
                       rows[i].known, {rows[i].want_num, rows[i].want_den});

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0)
            idle_on = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 2))
            0: span = 12;
            1: span = 1000;
            default: span = 50000;
         endcase
         n1 = pick_word(span);
         d1 = pick_word(span);
         n2 = pick_word(span);
         d2 = pick_word(span);
         // steer a share of items onto the shortcut paths
         kind = $urandom_range(0, 19);
         if (kind == 0)
            n2 = '0;
         else if (kind <= 3)
            d2 = d1;
         else if (kind <= 6)
            d2 = -d1;
         transfer_item(1'($urandom_range(0, 1)), n1, d1, n2, d2, 1'b0, '0);
      end
      @(negedge clock);
      start <= 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule

[rational_add_subtract_reduce.f]
src/rasr_pkg.sv
src/rational_add_subtract_reduce.sv
tb/sv/rational_add_subtract_reduce_tb.sv
